// ----- rtl/twsl_pkg.sv -----
// Package for the three-wheel slew limiter: widths, constants, state and divider interface types.
`timescale 1ns / 1ps
`default_nettype none
package twsl_pkg;
    localparam int SpeedW = 16;
    localparam int DutyW  = 16;
    localparam int CfgW   = 48;
    localparam int IdxW   = 3;

    localparam logic [IdxW-1:0] REG_MAX_ACCEL = 3'd0;
    localparam logic [IdxW-1:0] REG_ENABLE    = 3'd1;
    localparam logic [IdxW-1:0] REG_GAIN_F    = 3'd2;
    localparam logic [IdxW-1:0] REG_GAIN_BL   = 3'd3;
    localparam logic [IdxW-1:0] REG_GAIN_BR   = 3'd4;
    localparam logic [IdxW-1:0] REG_FWD_TRIM  = 3'd5;
    localparam logic [IdxW-1:0] REG_REV_TRIM  = 3'd6;

    // Width of the serial divider operands (dividend and divisor).
    localparam int DivW = 64;
    localparam int DivCntW = 7;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DELTA, ST_RAMP_DIV, ST_RAMP_NEXT,
        ST_SCALE, ST_MAP_DIV, ST_TRIM, ST_TRIM_NEXT,
        ST_NORM_MAX, ST_NORM_DIV, ST_NORM_NEXT, ST_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic [DivW-1:0] num;
        logic [DivW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
        logic [DivW-1:0] quo;
        logic [DivW-1:0] rem;
    } t_div_rsp;
endpackage
`default_nettype wire

// ----- rtl/twsl_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module twsl_div
    import twsl_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic [DivW-1:0]    r_quo, n_quo;
    logic [DivW-1:0]    r_rem, n_rem;
    logic [DivW-1:0]    r_den;
    logic [DivCntW-1:0] r_cnt, n_cnt;
    logic               r_busy, n_busy, r_done, n_done;
    logic [DivW:0]      w_trial;

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem, r_quo[DivW-1]} - {1'b0, r_den};
        if (i_req.start) begin
            n_quo  = i_req.num;
            n_rem  = '0;
            n_cnt  = DivCntW'(DivW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_trial[DivW]) begin
                n_rem = {r_rem[DivW-2:0], r_quo[DivW-1]};
                n_quo = {r_quo[DivW-2:0], 1'b0};
            end else begin
                n_rem = w_trial[DivW-1:0];
                n_quo = {r_quo[DivW-2:0], 1'b1};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == DivCntW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) begin
            r_den <= i_req.den;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule
`default_nettype wire

// ----- rtl/twsl_mul.sv -----
// Shift-and-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module twsl_mul
    import twsl_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [DivW-1:0] i_a,
    input  wire logic [31:0]     i_b,
    output logic                 o_done,
    output logic [DivW-1:0]      o_p
);
    logic [DivW-1:0] r_acc, r_a;
    logic [31:0]     r_b;
    logic [5:0]      r_cnt;
    logic            r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[DivW-2:0], 1'b0};
            r_b <= {1'b0, r_b[31:1]};
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;
endmodule
`default_nettype wire

// ----- rtl/three_wheel_slew_limit_pwm.sv -----
// Top level of the three-wheel slew limiter with PWM duty mapping.
`timescale 1ns / 1ps
`default_nettype none
// Each item carries three signed Q11.4 wheel targets and yields one item of
// three unsigned Q0.16 duties. Work runs on one shared bit-serial multiplier
// and one shared bit-serial divider, all magnitudes, with signs handled
// around them. Each lane takes a gain product, a calibration division and a
// trim product; when limiting applies, each lane's ramp step adds a product
// and a division, and renormalizing adds a division per lane. The result is
// held in an output register; the next item is taken once it has been
// delivered. Configuration writes take effect at once and must only be made
// while the block is idle.
module three_wheel_slew_limit_pwm
    import twsl_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    // tdata: target_back_left [15:0], target_back_right [31:16], target_front [47:32]
    input  wire logic [47:0]     s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire logic            m_axis_tready,
    // tdata: duty_front [15:0], duty_back_left [31:16], duty_back_right [47:32]
    output logic [47:0]          m_axis_tdata,
    input  wire logic            i_cfg_we,
    input  wire logic [IdxW-1:0] i_cfg_idx,
    input  wire logic [CfgW-1:0] i_cfg_data
);
    // Configuration registers.
    logic [14:0] r_max_accel;
    logic        r_enable;
    logic [15:0] r_gain [3];
    logic [47:0] r_fwd_trim, r_rev_trim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_accel <= 15'd480;
            r_enable    <= 1'b1;
            r_gain[0]   <= 16'd16384;
            r_gain[1]   <= 16'd16384;
            r_gain[2]   <= 16'd16384;
            r_fwd_trim  <= 48'h4000_4000_4000;
            r_rev_trim  <= 48'h4000_4000_4000;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_ACCEL: r_max_accel <= i_cfg_data[14:0];
                REG_ENABLE:    r_enable    <= i_cfg_data[0];
                REG_GAIN_F:    r_gain[0]   <= i_cfg_data[15:0];
                REG_GAIN_BL:   r_gain[1]   <= i_cfg_data[15:0];
                REG_GAIN_BR:   r_gain[2]   <= i_cfg_data[15:0];
                REG_FWD_TRIM:  r_fwd_trim  <= i_cfg_data;
                REG_REV_TRIM:  r_rev_trim  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Lane 0 is front, 1 back left, 2 back right; targets arrive in the
    // order back left, back right, front.
    t_state              r_state, n_state;
    logic signed [15:0]  r_ramp [3];
    logic signed [15:0]  r_tgt [3];
    logic signed [16:0]  r_delta [3];
    logic [16:0]         r_m;
    logic [1:0]          r_lane;
    logic                r_sub;      // second phase within a lane step
    logic                r_spos;     // scaled speed is positive
    logic                r_neg;      // sign of the operand being multiplied or divided
    logic signed [35:0]  r_s;        // scaled speed
    logic signed [22:0]  r_duty [3]; // duty before clamping
    logic [21:0]         r_mx;
    logic [47:0]         r_out;
    logic                r_ovalid;

    t_div_req w_dreq;
    t_div_rsp w_drsp;
    logic            w_mstart, w_mdone;
    logic [DivW-1:0] w_ma, w_mp;
    logic [31:0]     w_mb;

    twsl_div u_div (.i_clk, .i_rst_n, .i_req(w_dreq), .o_rsp(w_drsp));
    twsl_mul u_mul (.i_clk, .i_rst_n, .i_start(w_mstart), .i_a(w_ma), .i_b(w_mb),
                    .o_done(w_mdone), .o_p(w_mp));

    // Rounded quotient magnitude, halves away from zero: numerator was
    // offset by den/2 before division.
    logic [DivW-1:0] w_q;
    assign w_q = w_drsp.quo;

    // Calibration segment selection on the scaled speed (18 fraction bits).
    logic signed [47:0] w_s56;
    logic [12:0] w_k;
    logic [12:0] w_c;
    logic signed [63:0] w_inner;
    always_comb begin
        w_s56 = 48'(r_s) * 48'sd56;
        if (w_s56 > (48'sd4809 <<< 18) || w_s56 < -(48'sd4749 <<< 18)) begin
            w_k = 13'd6269; w_c = 13'd4993;
        end else if (r_s > 36'sd0) begin
            w_k = 13'd6186; w_c = 13'd5000;
        end else begin
            w_k = 13'd6235; w_c = 13'd4976;
        end
        // inner = 14*k*s + c*10000*2^18, duty = inner/(1e8*4) rounded.
        w_inner = 64'(r_s) * 64'(14 * 1) * $signed({51'd0, w_k})
                + $signed({51'd0, w_c}) * 64'sd2621440000;
    end

    logic [15:0] w_trim;
    always_comb begin
        case (r_lane)
            2'd0: w_trim = r_spos ? r_fwd_trim[15:0]  : r_rev_trim[15:0];
            2'd1: w_trim = r_spos ? r_fwd_trim[31:16] : r_rev_trim[31:16];
            default: w_trim = r_spos ? r_fwd_trim[47:32] : r_rev_trim[47:32];
        endcase
    end

    logic [16:0] w_abs [3];
    logic [16:0] w_mmax;
    logic        w_limit;
    logic signed [22:0] w_dev;
    logic [21:0] w_adev;
    logic signed [17:0] w_rsum;
    logic signed [19:0] w_nd;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_abs[i] = r_delta[i][16] ? 17'(-r_delta[i]) : 17'(r_delta[i]);
        end
        // Largest delta magnitude of the item just accepted.
        w_mmax = w_abs[0];
        if (w_abs[1] > w_mmax) w_mmax = w_abs[1];
        if (w_abs[2] > w_mmax) w_mmax = w_abs[2];
        w_limit = r_enable && (w_mmax != 17'd0) && (w_mmax >= {2'b0, r_max_accel});
        w_dev  = r_duty[r_lane] - 23'sd32768;
        w_adev = w_dev[22] ? 22'(-w_dev) : 22'(w_dev);
        w_rsum = 18'(r_ramp[r_lane]) + (r_neg ? -$signed({1'b0, w_q[16:0]})
                                              :  $signed({1'b0, w_q[16:0]}));
        w_nd   = 20'(r_neg ? -$signed({1'b0, w_q[17:0]}) : $signed({1'b0, w_q[17:0]}))
               + 20'sd32768;
    end

    assign s_axis_tready = (r_state == ST_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_out;

    always_comb begin
        n_state = r_state;
        w_dreq  = '0;
        w_mstart = 1'b0;
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            ST_IDLE:     if (s_axis_tvalid && s_axis_tready) n_state = ST_DELTA;
            ST_DELTA:    n_state = w_limit ? ST_RAMP_DIV : ST_SCALE;
            ST_RAMP_DIV: begin
                if (!r_sub) begin
                    w_mstart = 1'b1;
                    w_ma = DivW'(w_abs[r_lane]);
                    w_mb = 32'(r_max_accel);
                end else if (w_mdone) begin
                    w_dreq.start = 1'b1;
                    w_dreq.num = w_mp + DivW'(r_m >> 1);
                    w_dreq.den = DivW'(r_m);
                end
                if (w_drsp.done) n_state = ST_RAMP_NEXT;
            end
            ST_RAMP_NEXT: n_state = (r_lane == 2'd2) ? ST_SCALE : ST_RAMP_DIV;
            ST_SCALE: begin
                if (!r_sub) begin
                    w_mstart = 1'b1;
                    w_ma = DivW'(r_ramp[r_lane][15] ? 17'(-r_ramp[r_lane])
                                                    : 17'(r_ramp[r_lane]));
                    w_mb = 32'(r_gain[r_lane]);
                end else if (w_mdone) begin
                    n_state = ST_MAP_DIV;
                end
            end
            ST_MAP_DIV: begin
                if (!r_sub) begin
                    w_dreq.start = 1'b1;
                    w_dreq.num = (w_inner < 0 ? 64'(-w_inner) : 64'(w_inner))
                               + 64'd200000000;
                    w_dreq.den = 64'd400000000;
                end else if (w_drsp.done) begin
                    n_state = ST_TRIM;
                end
            end
            ST_TRIM: begin
                if (!r_sub) begin
                    w_mstart = 1'b1;
                    w_ma = DivW'(r_duty[r_lane][22] ? 23'(-r_duty[r_lane])
                                                    : 23'(r_duty[r_lane]));
                    w_mb = 32'(w_trim);
                end else if (w_mdone) begin
                    n_state = ST_TRIM_NEXT;
                end
            end
            ST_TRIM_NEXT: n_state = (r_lane == 2'd2) ? ST_NORM_MAX : ST_SCALE;
            ST_NORM_MAX:  n_state = (r_lane == 2'd2) ? ST_NORM_DIV : ST_NORM_MAX;
            ST_NORM_DIV: begin
                if (r_mx < 22'd32768) begin
                    n_state = ST_OUT;
                end else begin
                    if (!r_sub) begin
                        w_dreq.start = 1'b1;
                        w_dreq.num = (DivW'(w_adev) << 15) + DivW'(r_mx >> 1);
                        w_dreq.den = DivW'(r_mx);
                    end else if (w_drsp.done) begin
                        n_state = ST_NORM_NEXT;
                    end
                end
            end
            ST_NORM_NEXT: n_state = (r_lane == 2'd2) ? ST_OUT : ST_NORM_DIV;
            ST_OUT:       n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    function automatic logic [15:0] clamp_duty(input logic signed [22:0] d);
        if (d < 0) return 16'd0;
        if (d > 23'sd65535) return 16'hFFFF;
        return d[15:0];
    endfunction

    logic signed [63:0] w_tr;
    assign w_tr = (64'(w_mp) + 64'd8192) >> 14;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_ramp[0] <= '0; r_ramp[1] <= '0; r_ramp[2] <= '0;
            r_lane <= '0;
            r_sub  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (m_axis_tvalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    r_lane <= '0;
                    r_sub  <= 1'b0;
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_tgt[1] <= s_axis_tdata[15:0];
                        r_tgt[2] <= s_axis_tdata[31:16];
                        r_tgt[0] <= s_axis_tdata[47:32];
                        r_delta[1] <= 17'($signed(s_axis_tdata[15:0])) - 17'(r_ramp[1]);
                        r_delta[2] <= 17'($signed(s_axis_tdata[31:16])) - 17'(r_ramp[2]);
                        r_delta[0] <= 17'($signed(s_axis_tdata[47:32])) - 17'(r_ramp[0]);
                    end
                end
                ST_DELTA: begin
                    r_m <= w_mmax;
                    if (!w_limit) begin
                        r_ramp[0] <= r_tgt[0]; r_ramp[1] <= r_tgt[1];
                        r_ramp[2] <= r_tgt[2];
                    end
                end
                ST_RAMP_DIV: begin
                    r_neg <= r_delta[r_lane][16];
                    if (!r_sub) r_sub <= 1'b1;
                    if (w_drsp.done) begin
                        r_sub <= 1'b0;
                        if (w_q > 64'd131071 || w_rsum > 18'sd32767)
                            r_ramp[r_lane] <= r_neg ? -16'sd32768 : 16'sd32767;
                        else if (w_rsum < -18'sd32768)
                            r_ramp[r_lane] <= -16'sd32768;
                        else
                            r_ramp[r_lane] <= 16'(w_rsum);
                    end
                end
                ST_RAMP_NEXT: r_lane <= (r_lane == 2'd2) ? 2'd0 : r_lane + 1'b1;
                ST_SCALE: begin
                    if (!r_sub) begin
                        r_sub <= 1'b1;
                        r_neg <= r_ramp[r_lane][15];
                    end else if (w_mdone) begin
                        r_sub <= 1'b0;
                        r_s   <= r_neg ? -36'(w_mp) : 36'(w_mp);
                        r_spos <= !r_neg && (w_mp != '0);
                    end
                end
                ST_MAP_DIV: begin
                    if (!r_sub) begin
                        r_sub <= 1'b1;
                        r_neg <= w_inner < 0;
                    end else if (w_drsp.done) begin
                        r_sub <= 1'b0;
                        r_duty[r_lane] <= r_neg ? -23'(w_q) : 23'(w_q);
                    end
                end
                ST_TRIM: begin
                    if (!r_sub) begin
                        r_sub <= 1'b1;
                        r_neg <= r_duty[r_lane][22];
                    end else if (w_mdone) begin
                        r_sub <= 1'b0;
                        r_duty[r_lane] <= r_neg ? -23'(w_tr) : 23'(w_tr);
                    end
                end
                ST_TRIM_NEXT: begin
                    r_lane <= (r_lane == 2'd2) ? 2'd0 : r_lane + 1'b1;
                    r_mx   <= '0;
                end
                ST_NORM_MAX: begin
                    if (w_adev > r_mx) r_mx <= w_adev;
                    r_lane <= (r_lane == 2'd2) ? 2'd0 : r_lane + 1'b1;
                end
                ST_NORM_DIV: begin
                    if (!r_sub) begin
                        r_sub <= 1'b1;
                        r_neg <= w_dev[22];
                    end else if (w_drsp.done) begin
                        r_sub <= 1'b0;
                        r_duty[r_lane] <= 23'(w_nd);
                    end
                end
                ST_NORM_NEXT: r_lane <= (r_lane == 2'd2) ? 2'd0 : r_lane + 1'b1;
                ST_OUT: begin
                    r_ovalid <= 1'b1;
                    r_out <= {clamp_duty(r_duty[2]), clamp_duty(r_duty[1]),
                              clamp_duty(r_duty[0])};
                end
                default: ;
            endcase
        end
    end

    property p_div_free;
        @(posedge i_clk) disable iff (!i_rst_n)
            !(w_dreq.start && w_drsp.busy);
    endproperty
    a_div_free: assert property (p_div_free) else $error("divider started while busy");

    property p_no_overlap;
        @(posedge i_clk) disable iff (!i_rst_n)
            !(s_axis_tready && m_axis_tvalid);
    endproperty
    a_no_overlap: assert property (p_no_overlap)
        else $error("input taken while a result is pending");

    property p_out_after;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == ST_OUT) |=> m_axis_tvalid;
    endproperty
    a_out_after: assert property (p_out_after) else $error("result not presented");
endmodule
`default_nettype wire
